// ===== src/ccp_pkg.sv =====
// Shared types, constants and the CRC remainder function of the codeword packer.
`timescale 1ns / 1ps

package ccp_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int CMP_WIDTH       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int PENDING_WIDTH   = 3;

   localparam logic [7:0]  GENERATOR_RESET  = 8'd11;
   localparam logic [15:0] BYTE_COUNT_RESET = 16'd1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GENERATOR_BITS = 2'd0,
      CSR_WIDE_GENERATOR = 2'd1,
      CSR_SPLIT_NIBBLES  = 2'd2,
      CSR_BYTE_COUNT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  generator_bits;
      logic        wide_generator;
      logic        split_nibbles;
      logic [15:0] byte_count;
   } cfg_type;

   // One queue entry: all bytes caused by one input item, first byte at index 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_index;
      logic            end_of_stream;
   } entry_type;

   // Remainder of the dataword times x^c over the generator, leading bit implied.
   // A nibble sits in the top four bits of src and takes four steps.
   function automatic logic [6:0] crc_remainder(input logic [7:0] src,
                                                input logic       nibble,
                                                input logic       wide,
                                                input logic [7:0] gen);
      logic [6:0] mask;
      logic [6:0] poly;
      logic [6:0] rem;
      logic       fb;
      mask = wide ? 7'h7F : 7'h07;
      poly = gen[6:0] & mask;
      rem  = '0;
      fb   = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!nibble || (i < 4)) begin
            fb  = (wide ? rem[6] : rem[2]) ^ src[7-i];
            rem = (rem << 1) & mask;
            if (fb) begin
               rem = rem ^ poly;
            end
         end
      end
      return rem;
   endfunction

endpackage

// ===== src/ccp_front.sv =====
// Front end: accept data bytes, build codewords and cut the bit stream into byte entries.
`timescale 1ns / 1ps

module ccp_front
   import ccp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   input  logic [7:0] req_data_byte,
   output logic       req_stall,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_entry
);

   logic [6:0]             pend_bits_ff, pend_bits_in;   // left aligned, MSB first
   logic [2:0]             pend_fill_ff, pend_fill_in;
   logic                   header_sent_ff, header_sent_in;
   logic [COUNT_WIDTH-1:0] bytes_seen_ff, bytes_seen_in;

   logic                   start;
   logic [2:0]             total_low;
   logic [2:0]             bpb_low;
   logic [5:0]             pad_prod;
   logic [2:0]             pad;
   logic [2:0]             base_fill;
   logic [6:0]             base_bits;
   logic [6:0]             rem_full, rem_hi, rem_lo;
   logic [21:0]            code_left;
   logic [4:0]             code_len;
   logic [31:0]            window;
   logic [4:0]             stream_fill;
   logic [1:0]             full_bytes;
   logic [2:0]             leftover;
   logic [7:0]             stream_byte [4];
   logic [COUNT_WIDTH-1:0] seen_next;
   logic [15:0]            total;
   logic                   last;
   logic [2:0]             n_bytes;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign start     = !header_sent_ff;

   // Pad count only depends on the stream length modulo eight.
   always_comb begin
      total     = (cfg.byte_count == 16'd0) ? 16'd1 : cfg.byte_count;
      total_low = total[2:0];
      unique case ({cfg.split_nibbles, cfg.wide_generator})
         2'b00:   bpb_low = 3'd3;  // eleven bits
         2'b01:   bpb_low = 3'd7;  // fifteen bits
         2'b10:   bpb_low = 3'd6;  // fourteen bits
         default: bpb_low = 3'd6;  // twenty-two bits
      endcase
      pad_prod = {3'b000, total_low} * {3'b000, bpb_low};
      pad      = 3'd0 - pad_prod[2:0];
   end

   always_comb begin
      rem_full = crc_remainder(req_data_byte, 1'b0, cfg.wide_generator,
                               cfg.generator_bits);
      rem_hi   = crc_remainder({req_data_byte[7:4], 4'b0000}, 1'b1,
                               cfg.wide_generator, cfg.generator_bits);
      rem_lo   = crc_remainder({req_data_byte[3:0], 4'b0000}, 1'b1,
                               cfg.wide_generator, cfg.generator_bits);
      unique case ({cfg.split_nibbles, cfg.wide_generator})
         2'b00: begin
            code_left = {req_data_byte, rem_full[2:0], 11'b0};
            code_len  = 5'd11;
         end
         2'b01: begin
            code_left = {req_data_byte, rem_full, 7'b0};
            code_len  = 5'd15;
         end
         2'b10: begin
            code_left = {req_data_byte[7:4], rem_hi[2:0],
                         req_data_byte[3:0], rem_lo[2:0], 8'b0};
            code_len  = 5'd14;
         end
         default: begin
            code_left = {req_data_byte[7:4], rem_hi, req_data_byte[3:0], rem_lo};
            code_len  = 5'd22;
         end
      endcase
   end

   always_comb begin
      base_fill   = start ? pad : pend_fill_ff;
      base_bits   = start ? 7'd0 : pend_bits_ff;
      window      = {base_bits, 25'b0} | ({code_left, 10'b0} >> base_fill);
      stream_fill = {2'b00, base_fill} + code_len;
      full_bytes  = stream_fill[4:3];
      leftover    = stream_fill[2:0];
      for (int k = 0; k < 4; k++) begin
         stream_byte[k] = window[31-8*k -: 8];
      end
   end

   always_comb begin
      seen_next = bytes_seen_ff + COUNT_WIDTH'(1);
      last      = (CMP_WIDTH'(seen_next) >= CMP_WIDTH'(total)) ||
                  (seen_next == '0);
      n_bytes   = {2'b00, start} + {1'b0, full_bytes};
      if (last && (leftover != 3'd0) && (n_bytes != 3'd4)) begin
         n_bytes = n_bytes + 3'd1;
      end
      if (start) begin
         // Header first, stream bytes shifted up by one slot.
         q_entry.bytes[0] = {5'b0, pad};
         for (int j = 1; j < 4; j++) begin
            q_entry.bytes[j] = stream_byte[j-1];
         end
      end else begin
         for (int j = 0; j < 4; j++) begin
            q_entry.bytes[j] = stream_byte[j];
         end
      end
      q_entry.last_index    = 2'(n_bytes - 3'd1);
      q_entry.end_of_stream = last;
   end

   always_comb begin
      if (last) begin
         pend_bits_in   = '0;
         pend_fill_in   = '0;
         header_sent_in = 1'b0;
         bytes_seen_in  = '0;
      end else begin
         pend_bits_in   = stream_byte[full_bytes][7:1];
         pend_fill_in   = leftover;
         header_sent_in = 1'b1;
         bytes_seen_in  = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff   <= '0;
         pend_fill_ff   <= '0;
         header_sent_ff <= 1'b0;
         bytes_seen_ff  <= '0;
      end else if (q_push) begin
         pend_bits_ff   <= pend_bits_in;
         pend_fill_ff   <= pend_fill_in;
         header_sent_ff <= header_sent_in;
         bytes_seen_ff  <= bytes_seen_in;
      end
   end

endmodule

// ===== src/ccp_queue.sv =====
// Short entry queue between the front end and the output serialiser.
`timescale 1ns / 1ps

module ccp_queue
   import ccp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   entry_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;
   logic                       do_push, do_pop;

   assign full      = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QUEUE_PTR_WIDTH{1'b0}}, do_push}
                           - {{QUEUE_PTR_WIDTH{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/ccp_back.sv =====
// Back end: serialise each queued entry into output bytes, one per cycle unless rsp_stall holds it.
`timescale 1ns / 1ps

module ccp_back
   import ccp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_entry,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_stream
);

   entry_type  cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last, taken, done;

   assign rsp_valid         = cur_valid_ff;
   assign rsp_out_byte      = cur_ff.bytes[idx_ff];
   assign at_last           = (idx_ff == cur_ff.last_index);
   assign rsp_last_of_run   = at_last;
   assign rsp_end_of_stream = at_last && cur_ff.end_of_stream;
   assign taken             = cur_valid_ff && !rsp_stall;
   assign done              = taken && at_last;
   assign q_pop             = !q_empty && (!cur_valid_ff || done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (taken) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

endmodule

// ===== src/crc_codeword_packer.sv =====
// Top level of the CRC codeword packer: registers, front end, queue and serialiser.
`timescale 1ns / 1ps

// Each data byte on req_ becomes one 8-bit dataword, or two 4-bit datawords
// high nibble first, each followed by its 3 or 7 CRC check bits. The codeword
// bits are packed MSB first into bytes on rsp_. The first byte of a stream is
// a header holding the number of zero pad bits, which then lead the stream so
// that byte_count inputs fill whole bytes; after the byte_count-th input the
// stream closes, any leftover bits going out as one last zero-filled byte.
// The front end takes one byte a cycle while the queue has room and turns it
// into a queue entry of one to four output bytes; the serialiser sends one
// output byte a cycle unless rsp_stall holds it. The four-entry queue lets the
// two sides stall apart. The user must write registers through csr_ only while
// the block is idle; the block itself does not enforce this.

module crc_codeword_packer
   import ccp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic                       rsp_end_of_stream
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_full, q_push, q_empty, q_pop;
   entry_type push_entry, pop_entry;
   logic [PENDING_WIDTH-1:0] pending_ff, pending_in;
   logic      req_take, run_done;

   // Register writes: take the low bits of the data word for narrow registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GENERATOR_BITS: cfg_in.generator_bits = csr_write_data[7:0];
            CSR_WIDE_GENERATOR: cfg_in.wide_generator = csr_write_data[0];
            CSR_SPLIT_NIBBLES:  cfg_in.split_nibbles  = csr_write_data[0];
            CSR_BYTE_COUNT:     cfg_in.byte_count     = csr_write_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator_bits <= GENERATOR_RESET;
         cfg_ff.wide_generator <= 1'b0;
         cfg_ff.split_nibbles  <= 1'b0;
         cfg_ff.byte_count     <= BYTE_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   ccp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   ccp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_entry           (pop_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   // Count items taken whose runs are not yet fully delivered.
   assign req_take = req_valid && !req_stall;
   assign run_done = rsp_valid && !rsp_stall && rsp_last_of_run;

   always_comb begin
      pending_in = pending_ff + {{(PENDING_WIDTH-1){1'b0}}, req_take}
                              - {{(PENDING_WIDTH-1){1'b0}}, run_done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Queue plus serialiser never hold more items than they have room for.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PENDING_WIDTH'(QUEUE_DEPTH + 1))
      else $error("more items in flight than queue and serialiser can hold");

   // No output is offered without an item in flight.
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff == '0) |-> !rsp_valid)
      else $error("output offered with no item in flight");

   // An item taken into an empty block reaches the output through the queue and the serialiser register.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (pending_ff == '0)) |-> ##2 rsp_valid)
      else $error("item lost between front end and serialiser");

   // The input side stalls only while the queue is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pending_ff >= PENDING_WIDTH'(QUEUE_DEPTH)))
      else $error("input stalled with room left in the queue");

endmodule

// ===== sim/crc_codeword_packer_tb.sv =====
// Self-checking testbench of the CRC codeword packer with its own bit-level predictor.
`timescale 1ns / 1ps

module crc_codeword_packer_tb;
   import ccp_pkg::*;

   // One packed output byte as it should leave the rsp_ channel.
   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_stream;
   } packed_byte_type;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       csr_write_enable  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index         = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data    = '0;
   logic                       req_valid         = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_data_byte     = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_stall         = 1'b0;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_last_of_run;
   logic                       rsp_end_of_stream;

   crc_codeword_packer u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   // Data bytes still to be offered, and packed bytes still to arrive.
   logic [7:0]      data_bytes_pending[$];
   packed_byte_type packed_bytes_due[$];

   int unsigned mismatches    = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;
   bit          req_taken     = 1'b0;

   // Predictor copy of the registers.
   logic [7:0]  gen_reg   = GENERATOR_RESET;
   logic        wide_reg  = 1'b0;
   logic        split_reg = 1'b0;
   logic [15:0] count_reg = BYTE_COUNT_RESET;

   // Predictor copy of the packing state.
   logic [31:0] acc_bits  = '0;
   int unsigned acc_fill  = 0;
   bit          hdr_done  = 1'b0;
   logic [15:0] seen_count = '0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Dataword of n bits followed by its check bits; the implied leading
   // generator bit never enters the division.
   function automatic int unsigned make_codeword(input int unsigned data, input int unsigned n);
      int unsigned c;
      int unsigned mask;
      int unsigned g;
      int unsigned rem;
      int unsigned fb;
      c    = wide_reg ? 7 : 3;
      mask = (1 << c) - 1;
      g    = gen_reg & mask;
      rem  = 0;
      for (int i = 0; i < n; i++) begin
         fb  = ((rem >> (c - 1)) & 1) ^ ((data >> (n - 1 - i)) & 1);
         rem = (rem << 1) & mask;
         if (fb != 0) begin
            rem = rem ^ g;
         end
      end
      return (data << c) | rem;
   endfunction

   function automatic void append_bits(input int unsigned value, input int unsigned n);
      acc_bits = (acc_bits << n) | (value & ((1 << n) - 1));
      acc_fill = acc_fill + n;
   endfunction

   // Work out every packed byte one data byte causes and queue them in order.
   task automatic pack_codeword_bytes(input logic [7:0] d);
      int unsigned     total;
      int unsigned     c;
      int unsigned     tbits;
      int unsigned     n;
      logic [7:0]      outs[4];
      bit              closing;
      packed_byte_type pb;
      total = (count_reg == 0) ? 1 : count_reg;
      c     = wide_reg ? 7 : 3;
      n     = 0;
      // First byte of a stream: header with the pad count, pad bits lead.
      if (!hdr_done) begin
         tbits   = total * (split_reg ? 2 * (4 + c) : 8 + c);
         outs[n] = 8'((8 - (tbits & 7)) & 7);
         acc_bits = '0;
         acc_fill = outs[n];
         hdr_done = 1'b1;
         n++;
      end
      if (split_reg) begin
         append_bits(make_codeword(d[7:4], 4), 4 + c);
         append_bits(make_codeword(d[3:0], 4), 4 + c);
      end else begin
         append_bits(make_codeword(d, 8), 8 + c);
      end
      while (acc_fill >= 8 && n < 4) begin
         outs[n] = 8'(acc_bits >> (acc_fill - 8));
         acc_fill = acc_fill - 8;
         n++;
      end
      seen_count = seen_count + 16'd1;
      closing    = (seen_count >= total) || (seen_count == 0);
      if (closing) begin
         // Flush leftover bits, zero filled on the right, then go idle.
         if (acc_fill > 0 && n < 4) begin
            outs[n] = 8'(acc_bits << (8 - acc_fill));
            n++;
         end
         acc_bits   = '0;
         acc_fill   = 0;
         hdr_done   = 1'b0;
         seen_count = '0;
      end else if (acc_fill > 0) begin
         acc_bits = acc_bits & ((32'd1 << acc_fill) - 1);
      end else begin
         acc_bits = '0;
      end
      for (int k = 0; k < n; k++) begin
         pb.out_byte      = outs[k];
         pb.last_of_run   = (k == n - 1);
         pb.end_of_stream = closing && (k == n - 1);
         packed_bytes_due.push_back(pb);
      end
   endtask

   // Monitor: sample both handshakes at the rising edge, predict on accept,
   // check each arriving byte against the oldest one due.
   always @(posedge clock) begin
      packed_byte_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            pack_codeword_bytes(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (packed_bytes_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected byte %h last %b end %b", $time,
                        rsp_out_byte, rsp_last_of_run, rsp_end_of_stream);
            end else begin
               want = packed_bytes_due.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  mismatches++;
                  $display("%0t: out_byte expected %h actual %h", $time,
                           want.out_byte, rsp_out_byte);
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  mismatches++;
                  $display("%0t: last_of_run expected %b actual %b", $time,
                           want.last_of_run, rsp_last_of_run);
               end
               if (rsp_end_of_stream !== want.end_of_stream) begin
                  mismatches++;
                  $display("%0t: end_of_stream expected %b actual %b", $time,
                           want.end_of_stream, rsp_end_of_stream);
               end
            end
         end
      end
   end

   // Driver: advance to the next item only once the current one is taken;
   // never drop valid while stalled.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (data_bytes_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_data_byte <= data_bytes_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, or a long hold-off counted down here.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Wait until nothing is offered or due, then let the block settle.
   task automatic wait_drained();
      while (!(data_bytes_pending.size() == 0 && !req_valid && packed_bytes_due.size() == 0))
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Write all four registers back to back while idle; mirror them in the predictor.
   task automatic set_all_regs(input logic [7:0] gen, input logic wide, input logic split,
                               input logic [15:0] count);
      csr_index_type idx;
      for (int r = 0; r < 4; r++) begin
         idx = csr_index_type'(r);
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         case (idx)
            CSR_GENERATOR_BITS: begin
               csr_write_data <= {8'h00, gen};
               gen_reg = gen;
            end
            CSR_WIDE_GENERATOR: begin
               csr_write_data <= {15'h0000, wide};
               wide_reg = wide;
            end
            CSR_SPLIT_NIBBLES: begin
               csr_write_data <= {15'h0000, split};
               split_reg = split;
            end
            default: begin
               csr_write_data <= count;
               count_reg = count;
            end
         endcase
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [7:0]  gen;
      logic [15:0] count;
      int unsigned pick;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      // Directed: reset settings, single-byte streams, data extremes.
      @(posedge clock);
      data_bytes_pending = {8'h00, 8'hFF, 8'hA5, 8'h5A};
      wait_drained();

      // Zero generator (leading bit still implied), wide split, byte count zero.
      set_all_regs(8'h00, 1'b1, 1'b1, 16'd0);
      @(posedge clock);
      data_bytes_pending = {8'hFF, 8'h00, 8'hC3};
      wait_drained();

      // All-ones generator, wide whole bytes, three-byte streams.
      set_all_regs(8'hFF, 1'b1, 1'b0, 16'd3);
      @(posedge clock);
      data_bytes_pending = {8'h80, 8'h01, 8'h7F};
      wait_drained();

      // Largest byte count: leave a stream open.
      set_all_regs(8'h13, 1'b0, 1'b1, 16'hFFFF);
      @(posedge clock);
      data_bytes_pending = {8'h12, 8'h34, 8'h56, 8'hF0};
      wait_drained();

      // Lower the count below bytes taken and change width mid-stream:
      // next item closes the stream with a flush of leftover bits.
      set_all_regs(8'h07, 1'b1, 1'b1, 16'd2);
      @(posedge clock);
      data_bytes_pending = {8'h0F};
      wait_drained();

      set_all_regs(8'h8B, 1'b0, 1'b0, 16'd5);
      @(posedge clock);
      data_bytes_pending = {8'h3C, 8'hE1};
      wait_drained();

      // Random phases, cycling through the idling patterns.
      for (int p = 0; p < 8; p++) begin
         pick = $urandom_range(9);
         gen  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
         pick = $urandom_range(9);
         if (pick < 7) begin
            count = 16'($urandom_range(6, 1));
         end else if (pick == 7) begin
            count = 16'd0;
         end else if (pick == 8) begin
            count = 16'hFFFF;
         end else begin
            count = 16'($urandom_range(40, 1));
         end
         set_all_regs(gen, 1'($urandom_range(1)), 1'($urandom_range(1)), count);
         @(posedge clock);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 56;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 56;
            end
            default: begin
               send_idle_pct = 32;
               stall_pct     = 32;
            end
         endcase
         // Hold the receiver off long enough for the block to back up.
         if (p == 4) begin
            hold_request = 300;
         end
         if (p == 6) begin
            // Pause the sender half way until every due byte has come.
            repeat (17) data_bytes_pending.push_back(8'($urandom_range(255)));
            wait_drained();
            @(posedge clock);
            repeat (18) data_bytes_pending.push_back(8'($urandom_range(255)));
         end else begin
            repeat (35) data_bytes_pending.push_back(8'($urandom_range(255)));
         end
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (mismatches == 0 && packed_bytes_due.size() == 0) begin
         $display("crc_codeword_packer_tb OK");
      end else begin
         $display("crc_codeword_packer_tb NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("crc_codeword_packer_tb NOT OK");
      $finish;
   end

endmodule
